// File: sv/spfh_pkg.sv
// ----------------------------------------------------------------------------
// spfh_pkg
// Shared types and constants of the stride prefetch history block.
// ----------------------------------------------------------------------------
package spfh_pkg;

   localparam int LEN_W = 11;

   localparam logic [1:0] CMD_ACCESS   = 2'd0;
   localparam logic [1:0] CMD_POLL     = 2'd1;
   localparam logic [1:0] CMD_COMPLETE = 2'd2;

   localparam logic CSR_LOAD_ONLY      = 1'b0;
   localparam logic CSR_ISSUE_INTERVAL = 1'b1;

   localparam logic [31:0] ALIGN_MASK     = 32'hFFFF_FFF0;
   localparam logic [31:0] DEFAULT_STRIDE = 32'd16;
   localparam logic [LEN_W-1:0] DEFAULT_LEN   = LEN_W'(4);
   localparam logic [LEN_W-1:0] MIN_CHAIN_LEN = LEN_W'(4);
   localparam logic [LEN_W-1:0] MIN_ISSUE_LEN = LEN_W'(4);
   localparam logic [LEN_W-1:0] CHAIN_START   = LEN_W'(2);

   typedef struct packed {
      logic [31:0]      addr;
      logic [31:0]      stride;
      logic [LEN_W-1:0] len;
   } entry_type;

endpackage

// File: sv/spfh_store.sv
// ----------------------------------------------------------------------------
// spfh_store
// History memories: entry data, issued marks and duplicate marks, each with
// one write port and one registered read port sharing the addresses.
// ----------------------------------------------------------------------------
module spfh_store
   import spfh_pkg::*;
#(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic                             clock,
   input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
   input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
   input  logic                             we_entry,
   input  entry_type                        wentry,
   input  logic                             we_issued,
   input  logic                             wissued,
   input  logic                             we_dupe,
   input  logic                             wdupe,
   output entry_type                        rentry,
   output logic                             rissued,
   output logic                             rdupe
);

   entry_type entry_mem  [HISTORY_DEPTH];
   logic      issued_mem [HISTORY_DEPTH];
   logic      dupe_mem   [HISTORY_DEPTH];

   always_ff @(posedge clock) begin
      if (we_entry) begin
         entry_mem[waddr] <= wentry;
      end
      rentry <= entry_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (we_issued) begin
         issued_mem[waddr] <= wissued;
      end
      rissued <= issued_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (we_dupe) begin
         dupe_mem[waddr] <= wdupe;
      end
      rdupe <= dupe_mem[raddr];
   end

endmodule

// File: sv/stride_prefetch_history.sv
// ----------------------------------------------------------------------------
// stride_prefetch_history
// Stride prefetcher keeping a ring of recent aligned access addresses.
// ----------------------------------------------------------------------------
// One word is processed at a time and each word returns exactly one response
// word. A recorded access scans the history pairwise through a single read
// port of the entry memory: the stride search and the duplicate pass each
// take about N*N/2 reads for N stored entries, and a full history holds
// HISTORY_DEPTH-1 entries. A poll walks back from the newest entry, one
// entry per read. Completions, ignored stores and other commands go
// straight to the response.
module stride_prefetch_history
   import spfh_pkg::*;
#(
   parameter int HISTORY_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // access_addr, cycle
   input  logic [2:0]  req_tuser,   // cmd, is_load
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // request_addr
   output logic [0:0]  rsp_tuser,   // has_request
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam logic [AW:0]   DEPTH_W = (AW+1)'(HISTORY_DEPTH);
   localparam logic [AW-1:0] FULL    = AW'(HISTORY_DEPTH - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH_K   = 4'd1;
   localparam logic [3:0] S_SRCH_KD  = 4'd2;
   localparam logic [3:0] S_SRCH_M   = 4'd3;
   localparam logic [3:0] S_SRCH_MD  = 4'd4;
   localparam logic [3:0] S_WRITE    = 4'd5;
   localparam logic [3:0] S_DUP_K    = 4'd6;
   localparam logic [3:0] S_DUP_KD   = 4'd7;
   localparam logic [3:0] S_DUP_M    = 4'd8;
   localparam logic [3:0] S_DUP_MD   = 4'd9;
   localparam logic [3:0] S_POLL_K   = 4'd10;
   localparam logic [3:0] S_POLL_D   = 4'd11;
   localparam logic [3:0] S_RESP     = 4'd12;

   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_W) begin
         sum = sum - DEPTH_W;
      end
      return sum[AW-1:0];
   endfunction

   function automatic logic [31:0] mag(input logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

   logic [3:0]       state_ff, state_in;
   logic             load_only_ff, load_only_in;
   logic [15:0]      interval_ff, interval_in;
   logic [AW-1:0]    oldest_ff, oldest_in;
   logic [AW-1:0]    count_ff, count_in;
   logic             pending_ff, pending_in;
   logic [31:0]      pend_addr_ff, pend_addr_in;
   logic [31:0]      last_issue_ff, last_issue_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [AW-1:0]    m_ff, m_in;
   logic [AW-1:0]    wslot_ff, wslot_in;
   logic [31:0]      a_ff, a_in;
   logic [31:0]      cycle_ff, cycle_in;
   logic [31:0]      last_ff, last_in;
   logic [31:0]      cur_stride_ff, cur_stride_in;
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic [31:0]      best_stride_ff, best_stride_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic             di_ff, di_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_flag_ff, rsp_flag_in;
   logic [31:0]      rsp_addr_ff, rsp_addr_in;

   logic [AW-1:0] raddr, waddr;
   logic          we_entry, we_issued, we_dupe, wdupe;
   entry_type     wentry, rentry;
   logic          rissued, rdupe;

   logic [1:0]  in_cmd;
   logic        in_load;
   logic [31:0] in_addr, in_cycle;

   assign in_addr    = req_tdata[31:0];
   assign in_cycle   = req_tdata[63:32];
   assign in_cmd     = req_tuser[1:0];
   assign in_load    = req_tuser[2];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_flag_ff;

   spfh_store #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_store (
      .clock     (clock),
      .raddr     (raddr),
      .waddr     (waddr),
      .we_entry  (we_entry),
      .wentry    (wentry),
      .we_issued (we_issued),
      .wissued   (1'b0 == we_entry),
      .we_dupe   (we_dupe),
      .wdupe     (wdupe),
      .rentry    (rentry),
      .rissued   (rissued),
      .rdupe     (rdupe)
   );

   always_comb begin
      state_in       = state_ff;
      load_only_in   = load_only_ff;
      interval_in    = interval_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      pending_in     = pending_ff;
      pend_addr_in   = pend_addr_ff;
      last_issue_in  = last_issue_ff;
      k_in           = k_ff;
      m_in           = m_ff;
      wslot_in       = wslot_ff;
      a_in           = a_ff;
      cycle_in       = cycle_ff;
      last_in        = last_ff;
      cur_stride_in  = cur_stride_ff;
      cur_len_in     = cur_len_ff;
      best_stride_in = best_stride_ff;
      best_len_in    = best_len_ff;
      di_in          = di_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_flag_in    = rsp_flag_ff;
      rsp_addr_in    = rsp_addr_ff;
      raddr          = wslot_ff;
      waddr          = wslot_ff;
      we_entry       = 1'b0;
      we_issued      = 1'b0;
      we_dupe        = 1'b0;
      wdupe          = 1'b1;
      wentry         = '{addr: a_ff, stride: best_stride_ff, len: best_len_ff};

      if (csr_we) begin
         case (csr_index)
            CSR_LOAD_ONLY:      load_only_in = csr_wdata[0];
            CSR_ISSUE_INTERVAL: interval_in  = csr_wdata;
            default:            ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_RESP;
               case (in_cmd)
                  CMD_ACCESS: begin
                     if (!(load_only_ff && !in_load)) begin
                        a_in        = in_addr & ALIGN_MASK;
                        best_len_in = '0;
                        best_stride_in = '0;
                        k_in        = '0;
                        if (count_ff == FULL) begin
                           count_in  = count_ff - AW'(1);
                           oldest_in = slot(oldest_ff, AW'(1));
                        end
                        state_in = S_SRCH_K;
                     end
                  end
                  CMD_POLL: begin
                     if (!pending_ff && count_ff != '0 &&
                         (in_cycle - last_issue_ff) > {16'd0, interval_ff}) begin
                        cycle_in = in_cycle;
                        k_in     = count_ff;
                        state_in = S_POLL_K;
                     end
                  end
                  CMD_COMPLETE: pending_in = 1'b0;
                  default: ;
               endcase
            end
         end
         S_SRCH_K: begin
            if (k_ff == count_ff) begin
               state_in = S_WRITE;
            end else begin
               raddr    = slot(oldest_ff, k_ff);
               state_in = S_SRCH_KD;
            end
         end
         S_SRCH_KD: begin
            last_in       = rentry.addr;
            cur_stride_in = a_ff - rentry.addr;
            cur_len_in    = CHAIN_START;
            m_in          = k_ff;
            state_in      = S_SRCH_M;
         end
         S_SRCH_M: begin
            if (m_ff == '0) begin
               if (cur_stride_ff != '0 && cur_len_ff > MIN_CHAIN_LEN &&
                   (cur_len_ff > best_len_ff ||
                    (cur_len_ff == best_len_ff &&
                     mag(best_stride_ff) > mag(cur_stride_ff)))) begin
                  best_len_in    = cur_len_ff;
                  best_stride_in = cur_stride_ff;
               end
               k_in     = k_ff + AW'(1);
               state_in = S_SRCH_K;
            end else begin
               raddr    = slot(oldest_ff, m_ff - AW'(1));
               state_in = S_SRCH_MD;
            end
         end
         S_SRCH_MD: begin
            if (last_ff - rentry.addr == cur_stride_ff) begin
               cur_len_in = cur_len_ff + LEN_W'(1);
               last_in    = rentry.addr;
            end
            m_in     = m_ff - AW'(1);
            state_in = S_SRCH_M;
         end
         S_WRITE: begin
            waddr     = slot(oldest_ff, count_ff);
            we_entry  = 1'b1;
            we_issued = 1'b1;
            we_dupe   = 1'b1;
            wdupe     = 1'b0;
            if (best_len_ff == '0) begin
               wentry = '{addr: a_ff, stride: DEFAULT_STRIDE, len: DEFAULT_LEN};
            end
            k_in     = count_ff;
            count_in = count_ff + AW'(1);
            state_in = S_DUP_K;
         end
         S_DUP_K: begin
            raddr    = slot(oldest_ff, k_ff);
            wslot_in = slot(oldest_ff, k_ff);
            state_in = S_DUP_KD;
         end
         S_DUP_KD: begin
            last_in       = rentry.addr;
            cur_stride_in = rentry.stride;
            di_in         = rdupe;
            m_in          = k_ff;
            state_in      = S_DUP_M;
         end
         S_DUP_M: begin
            if (m_ff == '0) begin
               waddr   = wslot_ff;
               we_dupe = 1'b1;
               wdupe   = di_ff;
               if (k_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  k_in     = k_ff - AW'(1);
                  state_in = S_DUP_K;
               end
            end else begin
               raddr    = slot(oldest_ff, m_ff - AW'(1));
               state_in = S_DUP_MD;
            end
         end
         S_DUP_MD: begin
            waddr = slot(oldest_ff, m_ff - AW'(1));
            if (last_ff - rentry.addr == cur_stride_ff) begin
               we_dupe = 1'b1;
            end
            if (last_ff == rentry.addr && cur_stride_ff == rentry.stride) begin
               di_in = 1'b1;
            end
            m_in     = m_ff - AW'(1);
            state_in = S_DUP_M;
         end
         S_POLL_K: begin
            if (k_ff == '0) begin
               state_in = S_RESP;
            end else begin
               raddr    = slot(oldest_ff, k_ff - AW'(1));
               wslot_in = slot(oldest_ff, k_ff - AW'(1));
               state_in = S_POLL_D;
            end
         end
         S_POLL_D: begin
            if (!rissued && rentry.len >= MIN_ISSUE_LEN && !rdupe) begin
               waddr         = wslot_ff;
               we_issued     = 1'b1;
               last_issue_in = cycle_ff;
               pending_in    = 1'b1;
               pend_addr_in  = rentry.addr + rentry.stride;
               state_in      = S_RESP;
            end else begin
               k_in     = k_ff - AW'(1);
               state_in = S_POLL_K;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = pending_ff;
               rsp_addr_in  = pending_ff ? pend_addr_ff : 32'd0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         load_only_ff  <= 1'b1;
         interval_ff   <= 16'd10;
         oldest_ff     <= '0;
         count_ff      <= '0;
         pending_ff    <= 1'b0;
         pend_addr_ff  <= '0;
         last_issue_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_only_ff  <= load_only_in;
         interval_ff   <= interval_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         pending_ff    <= pending_in;
         pend_addr_ff  <= pend_addr_in;
         last_issue_ff <= last_issue_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      m_ff           <= m_in;
      wslot_ff       <= wslot_in;
      a_ff           <= a_in;
      cycle_ff       <= cycle_in;
      last_ff        <= last_in;
      cur_stride_ff  <= cur_stride_in;
      cur_len_ff     <= cur_len_in;
      best_stride_ff <= best_stride_in;
      best_len_ff    <= best_len_in;
      di_ff          <= di_in;
      rsp_flag_ff    <= rsp_flag_in;
      rsp_addr_ff    <= rsp_addr_in;
   end

endmodule
